// ===== hw/rtl/static_range_encoder_defines.svh =====
// Assertion macros shared by the static range encoder checker.
// No dependencies.
`ifndef STATIC_RANGE_ENCODER_DEFINES_SVH
`define STATIC_RANGE_ENCODER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/sre_pkg.sv =====
// Package for the static range encoder: constants, op codes, state type.
// No dependencies.
package sre_pkg;
	localparam int TotalShiftDef = 11;
	localparam int PendingLimitDef = 56;
	localparam logic [31:0] RangeInit = 32'hFFFF_FFFF;
	localparam logic [31:0] RangeFloor = 32'h0100_0000;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOCOMP = 2'd1,
		ST_OVF = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENORM,
		S_PRODUCE,
		S_RDWAIT,
		S_MULF,
		S_MULC,
		S_ADD,
		S_FNORM,
		S_RELHELD,
		S_RELFILL,
		S_TERM
	} state_t;
endpackage

// ===== hw/rtl/sre_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module sre_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/static_range_encoder.sv =====
// Static range encoder top level: sequencer, shared multiplier, output register.
// Depends on sre_pkg and sre_ram.
//
// Usage: one input channel (valid/stall) carries requests: op 0 loads one entry of the
// 256-entry frequency table, op 1 encodes a byte, op 2 flushes and ends the stream.
// Config port writes message_length; write it only while the block is idle.
// The result channel (valid/stall) carries out_byte, byte_valid, last and status.
// One request is worked at a time; stall is raised from acceptance until the
// sequencer is back in idle. A load leaves the sequencer in idle and raises no stall.
// An encode steps through range check, table read, multiply by freq, multiply by
// cum_low and add, both multiplies on the one shared 32x12 multiplier; no new
// request is taken until it is done. Each normalization byte passes a produce
// step; a byte that releases the held byte, or a carry into a pending run, also
// emits each 0xFF or 0x00 byte of the run. A finish checks low, flushes its bytes,
// releases the held byte and pending 0xFFs, then emits the terminal result (last set).
// A result shows on out_valid the cycle after it is emitted. When the receiver
// stalls, the result register holds and the sequencer waits; no result is lost.
// Reset clears the coder state and message_length; the table is undefined until loaded.
module static_range_encoder
	import sre_pkg::*;
#(
	parameter int TOTAL_SHIFT = TotalShiftDef,
	parameter int PENDING_LIMIT = PendingLimitDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  symbol,
	input  logic [11:0] freq,
	input  logic [10:0] cum_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic [1:0]  status
);
	localparam int PW = $clog2(PENDING_LIMIT + 1);

	state_t state_q, state_d;
	state_t resume, rel_dest;
	logic [31:0] msg_len_q, range_q, low_q, prod_cnt_q, r_q, mul_q;
	logic [7:0]  held_q, cur_byte_q, fill_q, sym_q;
	logic        held_v_q, fin_q, carry_q, flush_q;
	logic [PW-1:0] pend_q, cnt_q;
	logic [1:0]  failed_q;
	logic [2:0]  guard_q;
	logic [22:0] rdata, ent_q;
	logic [11:0] mul_b;
	logic [43:0] mul_res;
	logic [32:0] sum;
	logic [31:0] cnt_inc;

	logic emit, out_free, accept, enorm_go, fnorm_go, hit_len, pend_full;
	logic [7:0] e_byte;
	logic e_bv, e_last;
	logic [1:0] e_st;

	// Result register frees when empty or taken this cycle.
	assign out_free = !out_valid || !out_stall;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// Loop conditions: renormalize range, flush low, both capped at four bytes.
	assign enorm_go = (range_q < RangeFloor) && (guard_q < 3'd4);
	assign fnorm_go = (low_q != 32'd0) && (guard_q < 3'd4);
	assign cnt_inc = prod_cnt_q + 32'd1;
	assign hit_len = (cnt_inc == msg_len_q);
	assign pend_full = (pend_q >= PW'(PENDING_LIMIT));

	// Where to go after a produced byte, and after a release or carry run.
	assign resume = fin_q ? S_FNORM : S_ENORM;
	assign rel_dest = carry_q ? S_IDLE : (flush_q ? S_TERM : resume);

	// Table read address comes from the registered symbol; data lands in S_RDWAIT.
	sre_ram #(.Width(23), .Depth(256)) u_tab (
		.clk(clk), .we(accept && op == OP_LOAD), .waddr(symbol),
		.wdata({cum_low, freq}), .raddr(sym_q), .rdata(rdata)
	);

	// Shared multiplier: r times freq in S_MULF, times cum_low in S_MULC.
	assign mul_b = (state_q == S_MULC) ? {1'b0, ent_q[22:12]} : ent_q[11:0];
	assign mul_res = {12'd0, r_q} * {32'd0, mul_b};

	// Low increment; bit 32 is the carry into bytes already produced.
	assign sum = {1'b0, low_q} + {1'b0, mul_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (op == OP_ENCODE) begin
						state_d = (failed_q != ST_OK) ? S_IDLE :
							((msg_len_q == 32'd0) ? S_TERM : S_ENORM);
					end else if (op == OP_FINISH) begin
						state_d = (failed_q != ST_OK || msg_len_q == 32'd0) ? S_TERM : S_FNORM;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ENORM: state_d = enorm_go ? S_PRODUCE : S_RDWAIT;
			S_RDWAIT: state_d = S_MULF;
			S_MULF: state_d = (ent_q[11:0] == 12'd0) ? S_TERM : S_MULC;
			S_MULC: state_d = S_ADD;
			S_ADD: state_d = (sum[32] && pend_q != '0) ? S_RELHELD : S_IDLE;
			S_FNORM: state_d = fnorm_go ? S_PRODUCE : S_RELHELD;
			S_PRODUCE: begin
				priority if (hit_len) state_d = S_TERM;
				else if (cur_byte_q == 8'hFF) state_d = pend_full ? S_TERM : resume;
				else state_d = S_RELHELD;
			end
			S_RELHELD: begin
				if (!held_v_q || out_free) state_d = S_RELFILL;
			end
			S_RELFILL: begin
				if (cnt_q == '0) state_d = rel_dest;
			end
			S_TERM: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output selection for the result register.
	always_comb begin
		emit = 1'b0;
		e_byte = 8'd0;
		e_bv = 1'b0;
		e_last = 1'b0;
		e_st = ST_OK;
		unique case (state_q)
			S_RELHELD: begin
				emit = held_v_q; e_bv = 1'b1; e_byte = held_q;
			end
			S_RELFILL: begin
				emit = (cnt_q != '0); e_bv = 1'b1; e_byte = fill_q;
			end
			S_TERM: begin
				emit = 1'b1; e_last = fin_q; e_st = failed_q;
			end
			default: emit = 1'b0;
		endcase
	end

	// Sequencer datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			msg_len_q <= '0;
			range_q <= RangeInit;
			low_q <= '0;
			held_q <= '0;
			held_v_q <= 1'b0;
			pend_q <= '0;
			prod_cnt_q <= '0;
			failed_q <= ST_OK;
			out_valid <= 1'b0;
			out_byte <= '0;
			byte_valid <= 1'b0;
			last <= 1'b0;
			status <= ST_OK;
			fin_q <= 1'b0;
			carry_q <= 1'b0;
			flush_q <= 1'b0;
			cnt_q <= '0;
			guard_q <= '0;
			sym_q <= '0;
			cur_byte_q <= '0;
			fill_q <= '0;
			ent_q <= '0;
			r_q <= '0;
			mul_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) msg_len_q <= cfg_wdata;
			if (out_free) out_valid <= emit;
			if (emit && out_free) begin
				out_byte <= e_byte;
				byte_valid <= e_bv;
				last <= e_last;
				status <= e_st;
			end
			unique case (state_q)
				S_IDLE: begin
					guard_q <= '0;
					carry_q <= 1'b0;
					flush_q <= 1'b0;
					if (accept) begin
						sym_q <= symbol;
						fin_q <= (op == OP_FINISH);
						if ((op == OP_ENCODE || op == OP_FINISH) && failed_q == ST_OK
							&& msg_len_q == 32'd0) begin
							failed_q <= ST_NOCOMP;
						end
					end
				end
				S_ENORM: begin
					if (enorm_go) begin
						cur_byte_q <= low_q[31:24];
						range_q <= range_q << 8;
						low_q <= low_q << 8;
						guard_q <= guard_q + 3'd1;
					end
				end
				S_RDWAIT: begin
					ent_q <= rdata;
					r_q <= range_q >> TOTAL_SHIFT;
				end
				S_MULF: begin
					// Zero frequency fails; an oversized product saturates.
					if (ent_q[11:0] == 12'd0) failed_q <= ST_NOCOMP;
					else range_q <= (mul_res[43:32] != 12'd0) ? RangeInit : mul_res[31:0];
				end
				S_MULC: mul_q <= mul_res[31:0];
				S_ADD: begin
					low_q <= sum[31:0];
					if (sum[32]) begin
						if (held_v_q) held_q <= held_q + 8'd1;
						// Pending 0xFF bytes turn to 0x00; the last one becomes the held byte.
						if (pend_q != '0) begin
							cnt_q <= pend_q - PW'(1);
							fill_q <= 8'h00;
							cur_byte_q <= 8'h00;
							carry_q <= 1'b1;
						end
					end
				end
				S_FNORM: begin
					if (fnorm_go) begin
						cur_byte_q <= low_q[31:24];
						low_q <= low_q << 8;
						guard_q <= guard_q + 3'd1;
					end else begin
						cnt_q <= pend_q;
						fill_q <= 8'hFF;
						flush_q <= 1'b1;
					end
				end
				S_PRODUCE: begin
					prod_cnt_q <= cnt_inc;
					priority if (hit_len) begin
						failed_q <= ST_NOCOMP;
					end else if (cur_byte_q == 8'hFF) begin
						if (pend_full) failed_q <= ST_OVF;
						else pend_q <= pend_q + PW'(1);
					end else begin
						cnt_q <= pend_q;
						fill_q <= 8'hFF;
					end
				end
				S_RELFILL: begin
					if (cnt_q == '0) begin
						held_q <= cur_byte_q;
						held_v_q <= 1'b1;
						pend_q <= '0;
					end else if (out_free) begin
						cnt_q <= cnt_q - PW'(1);
					end
				end
				S_TERM: begin
					if (out_free && fin_q) begin
						range_q <= RangeInit; low_q <= '0; held_q <= '0;
						held_v_q <= 1'b0; pend_q <= '0; prod_cnt_q <= '0;
						failed_q <= ST_OK;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== hw/rtl/sre_checker.sv =====
// Port-level checker for the static range encoder, bound to the top level.
// Depends on static_range_encoder_defines.svh and sre_pkg.
`include "static_range_encoder_defines.svh"
module sre_checker
	import sre_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       byte_valid,
	input logic       last,
	input logic [1:0] status
);
	`SRE_ASSERT_IMP(a_byte_ok, clk, arst_n, out_valid && byte_valid, status == ST_OK && !last,
		"byte result carries status or last")
	`SRE_ASSERT_IMP(a_err_nobyte, clk, arst_n, out_valid && status != ST_OK, !byte_valid,
		"error result carries a byte")
	`SRE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"stalled result dropped")
	`SRE_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, in_valid,
		"stalled request dropped")
	`SRE_ASSERT_IMP(a_stat, clk, arst_n, out_valid,
		status == ST_OK || status == ST_NOCOMP || status == ST_OVF, "bad status code")
endmodule

bind static_range_encoder sre_checker u_sre_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .byte_valid(byte_valid),
	.last(last), .status(status)
);
